// ===== rtl/core/samb_pkg.sv =====
// samb_pkg: shared types and constants of the sprite affine matrix builder.
// No dependencies.
package samb_pkg;

    localparam int TABLE_LEN = 24;
    localparam logic signed [33:0] Q30_PI      = 34'sd3373259426;
    localparam logic signed [33:0] Q30_HALF_PI = 34'sd1686629713;
    localparam logic signed [33:0] Q30_GAIN    = 34'sd652032874;
    localparam logic [15:0] ALPHA_ONE = 16'd32768;

    localparam logic [2:0] REG_USE_PARENT = 3'd0;
    localparam logic [2:0] REG_PARENT_A   = 3'd1;
    localparam logic [2:0] REG_PARENT_B   = 3'd2;
    localparam logic [2:0] REG_PARENT_C   = 3'd3;
    localparam logic [2:0] REG_PARENT_D   = 3'd4;
    localparam logic [2:0] REG_PARENT_TX  = 3'd5;
    localparam logic [2:0] REG_PARENT_TY  = 3'd6;
    localparam logic [2:0] REG_PARENT_AL  = 3'd7;

    typedef struct packed {
        logic signed [15:0] angle;
        logic signed [31:0] scale_x;
        logic signed [31:0] scale_y;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic        [15:0] alpha;
    } samb_in_t;

    typedef struct packed {
        logic signed [31:0] out_a;
        logic signed [31:0] out_b;
        logic signed [31:0] out_c;
        logic signed [31:0] out_d;
        logic signed [31:0] out_tx;
        logic signed [31:0] out_ty;
        logic        [15:0] out_alpha;
    } samb_out_t;

    // Passenger data carried alongside the CORDIC pipe.
    typedef struct packed {
        logic signed [31:0] scale_x;
        logic signed [31:0] scale_y;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic        [15:0] alpha;
        logic               flip;
    } samb_side_t;

    function automatic logic signed [33:0] atan_q30(input int i);
        case (i)
            0:  atan_q30 = 34'sd843314857;
            1:  atan_q30 = 34'sd497837829;
            2:  atan_q30 = 34'sd263043837;
            3:  atan_q30 = 34'sd133525159;
            4:  atan_q30 = 34'sd67021687;
            5:  atan_q30 = 34'sd33543516;
            6:  atan_q30 = 34'sd16775851;
            7:  atan_q30 = 34'sd8388437;
            8:  atan_q30 = 34'sd4194283;
            9:  atan_q30 = 34'sd2097149;
            10: atan_q30 = 34'sd1048576;
            11: atan_q30 = 34'sd524288;
            12: atan_q30 = 34'sd262144;
            13: atan_q30 = 34'sd131072;
            14: atan_q30 = 34'sd65536;
            15: atan_q30 = 34'sd32768;
            16: atan_q30 = 34'sd16384;
            17: atan_q30 = 34'sd8192;
            18: atan_q30 = 34'sd4096;
            19: atan_q30 = 34'sd2048;
            20: atan_q30 = 34'sd1024;
            21: atan_q30 = 34'sd512;
            22: atan_q30 = 34'sd256;
            23: atan_q30 = 34'sd128;
            default: atan_q30 = 34'sd0;
        endcase
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
        if (v > 72'sd2147483647)
            sat32 = 32'sh7FFFFFFF;
        else if (v < -72'sd2147483648)
            sat32 = 32'sh80000000;
        else
            sat32 = v[31:0];
    endfunction

endpackage

// ===== rtl/core/sprite_affine_matrix_builder_core.sv =====
// sprite_affine_matrix_builder_core: top level of the affine matrix builder.
// Depends on samb_pkg and samb_cordic.
//
// One item is taken per cycle when start is high; busy is always low since
// the pipe never stalls and the receiver cannot hold results off. Each result
// appears on result with done high for one cycle, after the input register,
// the CORDIC_STAGES rotation stages and four matrix stages, and is taken at
// the edge after that. Items leave in order. Configuration writes go in at
// any edge with cfg_we high but are meant to happen while no items are in
// flight; the parent registers are read in stages M3 and M4.
module sprite_affine_matrix_builder_core import samb_pkg::*; #(
    parameter int FRAC_BITS     = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  samb_in_t    item,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output logic        done,
    output samb_out_t   result
);
    // config registers
    logic               use_parent_reg;
    logic signed [31:0] pa_reg, pb_reg, pc_reg, pd_reg, ptx_reg, pty_reg;
    logic        [15:0] palpha_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use_parent_reg <= 1'b0;
            pa_reg <= 32'sd65536;
            pb_reg <= '0;
            pc_reg <= '0;
            pd_reg <= 32'sd65536;
            ptx_reg <= '0;
            pty_reg <= '0;
            palpha_reg <= ALPHA_ONE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_USE_PARENT: use_parent_reg <= cfg_data[0];
                REG_PARENT_A:   pa_reg <= cfg_data;
                REG_PARENT_B:   pb_reg <= cfg_data;
                REG_PARENT_C:   pc_reg <= cfg_data;
                REG_PARENT_D:   pd_reg <= cfg_data;
                REG_PARENT_TX:  ptx_reg <= cfg_data;
                REG_PARENT_TY:  pty_reg <= cfg_data;
                REG_PARENT_AL:  palpha_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // angle to Q.30 and fold into +-pi/2
    logic signed [33:0] z_raw, z_fold;
    logic               flip;
    samb_side_t         side_in;

    assign z_raw = {{1{item.angle[15]}}, item.angle, 17'd0};
    always_comb
    begin
        flip = 1'b0;
        z_fold = z_raw;
        if (z_raw > Q30_HALF_PI)
        begin
            z_fold = z_raw - Q30_PI;
            flip = 1'b1;
        end
        else if (z_raw < -Q30_HALF_PI)
        begin
            z_fold = z_raw + Q30_PI;
            flip = 1'b1;
        end
    end

    assign side_in = '{scale_x: item.scale_x, scale_y: item.scale_y, pos_x: item.pos_x,
                       pos_y: item.pos_y, alpha: item.alpha, flip: flip};

    logic               cv;
    logic signed [33:0] cos_q30, sin_q30;
    samb_side_t         cside;

    samb_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .in_z      (z_fold),
        .in_side   (side_in),
        .out_valid (cv),
        .cos_q30   (cos_q30),
        .sin_q30   (sin_q30),
        .out_side  (cside)
    );

    // Stage M1: local matrix products (34 x 32)
    logic               m1_v_reg;
    logic signed [71:0] p_a_reg, p_b_reg, p_c_reg, p_d_reg;
    logic signed [31:0] m1_tx_reg, m1_ty_reg;
    logic        [15:0] m1_al_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) m1_v_reg <= 1'b0;
        else        m1_v_reg <= cv;
    end

    always_ff @(posedge clk)
    begin
        p_a_reg <= 72'(72'(cos_q30) * cside.scale_x);
        p_b_reg <= 72'(72'(sin_q30) * cside.scale_y);
        p_c_reg <= 72'(-(72'(sin_q30)) * cside.scale_x);
        p_d_reg <= 72'(72'(cos_q30) * cside.scale_y);
        m1_tx_reg <= cside.pos_x;
        m1_ty_reg <= cside.pos_y;
        m1_al_reg <= cside.alpha;
    end

    // Stage M2: round and saturate local entries
    logic               m2_v_reg;
    logic signed [31:0] m_reg [6];
    logic        [15:0] m2_al_reg;
    localparam logic signed [71:0] HALF30 = 72'sd536870912;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) m2_v_reg <= 1'b0;
        else        m2_v_reg <= m1_v_reg;
    end

    always_ff @(posedge clk)
    begin
        m_reg[0] <= sat32((p_a_reg + HALF30) >>> 30);
        m_reg[1] <= sat32((p_b_reg + HALF30) >>> 30);
        m_reg[2] <= sat32((p_c_reg + HALF30) >>> 30);
        m_reg[3] <= sat32((p_d_reg + HALF30) >>> 30);
        m_reg[4] <= m1_tx_reg;
        m_reg[5] <= m1_ty_reg;
        m2_al_reg <= m1_al_reg;
    end

    // Stage M3: parent products (32 x 32), twelve of them plus alpha
    logic               m3_v_reg;
    logic signed [63:0] q_reg [12];
    logic signed [31:0] m3_m_reg [6];
    logic        [31:0] m3_al_prod_reg;
    logic        [15:0] m3_al_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) m3_v_reg <= 1'b0;
        else        m3_v_reg <= m2_v_reg;
    end

    always_ff @(posedge clk)
    begin
        for (int r = 0; r < 3; r++)
        begin
            q_reg[4*r+0] <= m_reg[2*r] * pa_reg;
            q_reg[4*r+1] <= m_reg[2*r+1] * pc_reg;
            q_reg[4*r+2] <= m_reg[2*r] * pb_reg;
            q_reg[4*r+3] <= m_reg[2*r+1] * pd_reg;
        end
        for (int k = 0; k < 6; k++) m3_m_reg[k] <= m_reg[k];
        m3_al_prod_reg <= m2_al_reg * palpha_reg;
        m3_al_reg <= m2_al_reg;
    end

    // Stage M4: round, sum, saturate, select
    localparam logic signed [63:0] HALFF = 64'sd1 <<< (FRAC_BITS - 1);
    logic               o_v_reg;
    samb_out_t          o_reg;
    logic signed [71:0] rsum [6];
    logic        [16:0] al_mix;
    logic        [15:0] al_sel;

    always_comb
    begin
        for (int k = 0; k < 6; k++)
        begin
            rsum[k] = 72'((q_reg[2*k] + HALFF) >>> FRAC_BITS)
                    + 72'((q_reg[2*k+1] + HALFF) >>> FRAC_BITS);
        end
        rsum[4] = rsum[4] + 72'(ptx_reg);
        rsum[5] = rsum[5] + 72'(pty_reg);
        al_mix = 17'((m3_al_prod_reg + 32'd16384) >> 15);
        if (use_parent_reg)
            al_sel = (al_mix > 17'(ALPHA_ONE)) ? ALPHA_ONE : al_mix[15:0];
        else
            al_sel = (m3_al_reg > ALPHA_ONE) ? ALPHA_ONE : m3_al_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) o_v_reg <= 1'b0;
        else        o_v_reg <= m3_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (use_parent_reg)
        begin
            o_reg.out_a  <= sat32(rsum[0]);
            o_reg.out_b  <= sat32(rsum[1]);
            o_reg.out_c  <= sat32(rsum[2]);
            o_reg.out_d  <= sat32(rsum[3]);
            o_reg.out_tx <= sat32(rsum[4]);
            o_reg.out_ty <= sat32(rsum[5]);
        end
        else
        begin
            o_reg.out_a  <= m3_m_reg[0];
            o_reg.out_b  <= m3_m_reg[1];
            o_reg.out_c  <= m3_m_reg[2];
            o_reg.out_d  <= m3_m_reg[3];
            o_reg.out_tx <= m3_m_reg[4];
            o_reg.out_ty <= m3_m_reg[5];
        end
        o_reg.out_alpha <= al_sel;
    end

    assign done   = o_v_reg;
    assign result = o_reg;

    // Checks
    a_busy_low: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");
    a_alpha_max: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> result.out_alpha <= ALPHA_ONE)
        else $error("alpha above one");
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        m3_v_reg |=> done)
        else $error("item lost in last stage");
endmodule

// ===== rtl/core/samb_cordic.sv =====
// samb_cordic: pipelined rotation-mode CORDIC, one stage per register.
// Depends on samb_pkg. Carries a side payload with each item.
module samb_cordic import samb_pkg::*; #(
    parameter int STAGES = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic signed [33:0]  in_z,
    input  samb_side_t          in_side,
    output logic                out_valid,
    output logic signed [33:0]  cos_q30,
    output logic signed [33:0]  sin_q30,
    output samb_side_t          out_side
);
    logic               v_reg [STAGES+1];
    logic signed [33:0] x_reg [STAGES+1];
    logic signed [33:0] y_reg [STAGES+1];
    logic signed [33:0] z_reg [STAGES+1];
    samb_side_t         s_reg [STAGES+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg[0] <= Q30_GAIN;
        y_reg[0] <= '0;
        z_reg[0] <= in_z;
        s_reg[0] <= in_side;
    end

    for (genvar i = 0; i < STAGES; i++)
    begin : g_stage
        logic signed [33:0] dx, dy;
        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i+1] <= 1'b0;
            end
            else
            begin
                v_reg[i+1] <= v_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            s_reg[i+1] <= s_reg[i];
            if (!z_reg[i][33])
            begin
                x_reg[i+1] <= x_reg[i] - dx;
                y_reg[i+1] <= y_reg[i] + dy;
                z_reg[i+1] <= z_reg[i] - atan_q30(i);
            end
            else
            begin
                x_reg[i+1] <= x_reg[i] + dx;
                y_reg[i+1] <= y_reg[i] - dy;
                z_reg[i+1] <= z_reg[i] + atan_q30(i);
            end
        end
    end

    assign out_valid = v_reg[STAGES];
    assign cos_q30   = s_reg[STAGES].flip ? -x_reg[STAGES] : x_reg[STAGES];
    assign sin_q30   = s_reg[STAGES].flip ? -y_reg[STAGES] : y_reg[STAGES];
    assign out_side  = s_reg[STAGES];
endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: self-checking bench for sprite_affine_matrix_builder_core.
// Depends on samb_pkg and the core; holds its own fixed-point matrix predictor.
module tb_top;
    import samb_pkg::*;

    localparam int FRAC = 16;
    localparam int STAGES = 16;
    localparam int LATENCY = STAGES + 5;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    samb_in_t    item;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        done;
    samb_out_t   result;

    sprite_affine_matrix_builder_core #(.FRAC_BITS(FRAC), .CORDIC_STAGES(STAGES)) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .done(done), .result(result)
    );

    // Shadow copy of the configuration registers
    logic        sh_use_parent;
    logic signed [31:0] sh_parent [0:5];
    logic [15:0] sh_parent_alpha;

    samb_in_t  pending_items[$];
    int        pending_gaps[$];
    samb_out_t expected_matrices[$];
    int        error_count;
    int        items_sent;
    int        matrices_seen;
    int        gap_left;

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic longint asr(longint v, int s);
        return v >>> s;
    endfunction

    // Round-half-up product with an arithmetic shift; operands fit 64 bits.
    function automatic longint round_mul(longint a, longint b, int sh);
        return asr(a * b + (longint'(1) << (sh - 1)), sh);
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint arctan_q30(int i);
        longint tbl[24] = '{843314857, 497837829, 263043837, 133525159,
            67021687, 33543516, 16775851, 8388437, 4194283, 2097149,
            1048576, 524288, 262144, 131072, 65536, 32768, 16384, 8192,
            4096, 2048, 1024, 512, 256, 128};
        return tbl[i];
    endfunction

    // Builds rotation * scale * translation, then applies the parent if enabled.
    function automatic samb_out_t compose_matrix(samb_in_t it);
        samb_out_t o;
        longint z, x, y, dx, dy, cs, sn, al;
        longint m[6];
        longint r[6];
        longint p[6];
        bit flip;
        z = longint'(it.angle) * 131072;
        x = 652032874;
        y = 0;
        flip = 1'b0;
        if (z > 64'sd1686629713)
        begin
            z -= 64'sd3373259426;
            flip = 1'b1;
        end
        else if (z < -64'sd1686629713)
        begin
            z += 64'sd3373259426;
            flip = 1'b1;
        end
        for (int i = 0; i < STAGES && i < 24; i++)
        begin
            dx = asr(y, i);
            dy = asr(x, i);
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= arctan_q30(i);
            end
            else
            begin
                x += dx;
                y -= dy;
                z += arctan_q30(i);
            end
        end
        cs = flip ? -x : x;
        sn = flip ? -y : y;
        m[0] = clamp32(round_mul(cs, longint'(it.scale_x), 30));
        m[1] = clamp32(round_mul(sn, longint'(it.scale_y), 30));
        m[2] = clamp32(round_mul(-sn, longint'(it.scale_x), 30));
        m[3] = clamp32(round_mul(cs, longint'(it.scale_y), 30));
        m[4] = longint'(it.pos_x);
        m[5] = longint'(it.pos_y);
        al = longint'(it.alpha);
        if (sh_use_parent)
        begin
            for (int i = 0; i < 6; i++)
                p[i] = longint'(sh_parent[i]);
            for (int i = 0; i < 6; i += 2)
            begin
                r[i] = round_mul(m[i], p[0], FRAC) + round_mul(m[i + 1], p[2], FRAC);
                r[i + 1] = round_mul(m[i], p[1], FRAC) + round_mul(m[i + 1], p[3], FRAC);
            end
            r[4] += p[4];
            r[5] += p[5];
            for (int i = 0; i < 6; i++)
                m[i] = clamp32(r[i]);
            al = (al * longint'(sh_parent_alpha) + 16384) >>> 15;
        end
        if (al > 32768)
            al = 32768;
        o.out_a = m[0][31:0];
        o.out_b = m[1][31:0];
        o.out_c = m[2][31:0];
        o.out_d = m[3][31:0];
        o.out_tx = m[4][31:0];
        o.out_ty = m[5][31:0];
        o.out_alpha = al[15:0];
        return o;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("  item %0d %s: got %0d expected %0d", matrices_seen, what, got, want);
        error_count++;
    endtask

    // Driver: feeds queued items at the falling edge, with queued gaps.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                start <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                item <= pending_items[0];
                start <= 1'b1;
                gap_left <= pending_gaps[0];
                pending_items.pop_front();
                pending_gaps.pop_front();
            end
            else
                start <= 1'b0;
        end
    end

    // Acceptance: predict at the edge that takes the item.
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
        begin
            expected_matrices.push_back(compose_matrix(item));
            items_sent++;
        end
    end

    // Monitor: compare each strobed result with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_matrices.size() == 0)
            begin
                $display("  unexpected result");
                error_count++;
            end
            else
            begin
                samb_out_t w;
                w = expected_matrices.pop_front();
                if (result.out_a !== w.out_a)
                    report_mismatch("out_a", result.out_a, w.out_a);
                if (result.out_b !== w.out_b)
                    report_mismatch("out_b", result.out_b, w.out_b);
                if (result.out_c !== w.out_c)
                    report_mismatch("out_c", result.out_c, w.out_c);
                if (result.out_d !== w.out_d)
                    report_mismatch("out_d", result.out_d, w.out_d);
                if (result.out_tx !== w.out_tx)
                    report_mismatch("out_tx", result.out_tx, w.out_tx);
                if (result.out_ty !== w.out_ty)
                    report_mismatch("out_ty", result.out_ty, w.out_ty);
                if (result.out_alpha !== w.out_alpha)
                    report_mismatch("out_alpha", result.out_alpha, w.out_alpha);
            end
            matrices_seen++;
        end
    end

    function automatic logic [31:0] rand_q16();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'($signed($urandom_range(0, 262143)) - 131072);
            3: return 32'($signed($urandom_range(0, 8191)) - 4096);
            default: return $urandom();
        endcase
    endfunction

    function automatic int rand_gap();
        int k;
        k = $urandom_range(0, 99);
        if (k < 55)
            return 0;
        if (k < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic samb_in_t rand_item();
        samb_in_t it;
        it.angle = 16'($signed($urandom_range(0, 65535)));
        if ($urandom_range(0, 3) != 0)
            it.angle = 16'($signed($urandom_range(0, 51472)) - 25736);
        it.scale_x = rand_q16();
        it.scale_y = rand_q16();
        it.pos_x = rand_q16();
        it.pos_y = rand_q16();
        case ($urandom_range(0, 5))
            0: it.alpha = 16'hFFFF;
            1: it.alpha = 16'($urandom_range(32768, 65535));
            default: it.alpha = 16'($urandom_range(0, 32768));
        endcase
        return it;
    endfunction

    task automatic queue_item(samb_in_t it, int gap);
        pending_items.push_back(it);
        pending_gaps.push_back(gap);
    endtask

    // Register write while idle, mirrored into the shadow copy.
    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_USE_PARENT)
            sh_use_parent = val[0];
        else if (idx == REG_PARENT_AL)
            sh_parent_alpha = val[15:0];
        else
            sh_parent[idx - 1] = val;
    endtask

    task automatic wait_idle();
        while (pending_items.size() > 0 || expected_matrices.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic random_phase(int count);
        for (int i = 0; i < count; i++)
            queue_item(rand_item(), (i % 200 < 60) ? 0 : rand_gap());
        wait_idle();
    endtask

    initial
    begin
        samb_in_t it;
        logic signed [15:0] angles[8] = '{16'sd0, 16'sd25736, -16'sd25736,
            16'sd12868, -16'sd12868, 16'sh7FFF, 16'sh8000, 16'sd12869};
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        cfg_we = 1'b0;
        cfg_index = REG_USE_PARENT;
        cfg_data = '0;
        gap_left = 0;
        error_count = 0;
        items_sent = 0;
        matrices_seen = 0;
        sh_use_parent = 1'b0;
        sh_parent = '{32'sd65536, 32'sd0, 32'sd0, 32'sd65536, 32'sd0, 32'sd0};
        sh_parent_alpha = ALPHA_ONE;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: angle extremes and folding, saturation, alpha above one.
        foreach (angles[i])
        begin
            it.angle = angles[i];
            it.scale_x = 32'sd65536;
            it.scale_y = -32'sd131072;
            it.pos_x = 32'sh7FFFFFFF;
            it.pos_y = 32'sh80000000;
            it.alpha = 16'd32768;
            queue_item(it, i % 2);
        end
        it = '{16'sd6434, 32'sh7FFFFFFF, 32'sh80000000, 32'sd0, -32'sd1, 16'hFFFF};
        queue_item(it, 0);
        it = '{-16'sd6434, 32'sh80000000, 32'sh7FFFFFFF, 32'sd1, 32'sd0, 16'd0};
        queue_item(it, 0);
        it = '{16'sd1, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 16'd32769};
        queue_item(it, 3);
        wait_idle();

        random_phase(350);

        // Parent on, identity parent with half alpha.
        write_reg(REG_USE_PARENT, 32'd1);
        write_reg(REG_PARENT_AL, 32'd16384);
        random_phase(250);

        // Extreme parent entries force saturation of the products.
        write_reg(REG_PARENT_A, 32'h7FFFFFFF);
        write_reg(REG_PARENT_B, 32'h80000000);
        write_reg(REG_PARENT_C, 32'h80000000);
        write_reg(REG_PARENT_D, 32'h7FFFFFFF);
        write_reg(REG_PARENT_TX, 32'h7FFFFFFF);
        write_reg(REG_PARENT_TY, 32'h80000000);
        write_reg(REG_PARENT_AL, 32'h0000FFFF);
        random_phase(250);

        // Random parent, alpha zero, then full opacity.
        for (int r = 0; r < 2; r++)
        begin
            write_reg(REG_PARENT_A, rand_q16());
            write_reg(REG_PARENT_B, rand_q16());
            write_reg(REG_PARENT_C, rand_q16());
            write_reg(REG_PARENT_D, rand_q16());
            write_reg(REG_PARENT_TX, rand_q16());
            write_reg(REG_PARENT_TY, rand_q16());
            write_reg(REG_PARENT_AL, r == 0 ? 32'd0 : 32'd32768);
            random_phase(200);
        end

        // Parent off again while parent registers hold odd values.
        write_reg(REG_USE_PARENT, 32'hFFFF_FFFE);
        random_phase(190);

        $display("Covered %0d items, %0d results, parent on and off.", items_sent,
            matrices_seen);
        if (error_count == 0 && expected_matrices.size() == 0)
            $display("sprite_affine_matrix_builder_core: match");
        else
            $display("sprite_affine_matrix_builder_core: mismatch");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("sprite_affine_matrix_builder_core: mismatch");
        $finish;
    end
endmodule
